// File: rtl/isodur_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISO duration parser package
// Parser phase type, character codes, unit multipliers and datapath widths.
// ----------------------------------------------------------------------------
package isodur_pkg;

    typedef enum logic [2:0] {
        PH_EXPECT_P = 3'd0,
        PH_TOKEN    = 3'd1,
        PH_SPACE    = 3'd2,
        PH_SIGN     = 3'd3,
        PH_DIGITS   = 3'd4,
        PH_ENDED    = 3'd5
    } phase_t;

    localparam int CH_W    = 8;
    localparam int NUM_W   = 32;
    localparam int SEC_W   = 31;
    localparam int DIGIT_W = 4;
    localparam int MULT_W  = 17;
    localparam int MAC_W   = NUM_W + MULT_W + 1;
    localparam int DEC_W   = NUM_W + 4;

    localparam logic [NUM_W-1:0] SAT_LIMIT = 32'h8000_0000;

    localparam logic [MULT_W-1:0] MULT_DAY  = 17'd86400;
    localparam logic [MULT_W-1:0] MULT_HOUR = 17'd3600;
    localparam logic [MULT_W-1:0] MULT_MIN  = 17'd60;

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_D     = 8'h44;
    localparam logic [CH_W-1:0] CH_H     = 8'h48;
    localparam logic [CH_W-1:0] CH_M     = 8'h4D;
    localparam logic [CH_W-1:0] CH_P     = 8'h50;
    localparam logic [CH_W-1:0] CH_S     = 8'h53;
    localparam logic [CH_W-1:0] CH_T     = 8'h54;

endpackage

// File: rtl/iso_duration_to_seconds_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISO 8601 duration to seconds
// Parses a duration string one character per transaction and returns the
// total length in seconds on the transaction that carries the last character.
// ----------------------------------------------------------------------------
// Feed the string one ASCII character per transaction, with last set on the
// final one; a single result (seconds) follows for that character only, 0 on
// any malformed string, a negative nonzero number, a missing unit or a total
// above 2^31-1. The block takes one character every cycle: a character is
// captured in an input register, and from there the parser state is
// updated by one multiply-add with saturation (digit accumulation, or number
// times the unit's constant added to the total), which sets the cycle time.
// A result enters the output register as its last character is processed
// from the input register. Characters keep flowing while a result waits;
// only a last character stalls when the output register is still occupied.
// ----------------------------------------------------------------------------
module iso_duration_to_seconds_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [isodur_pkg::CH_W-1:0]   ch,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [isodur_pkg::SEC_W-1:0]  seconds
);
    import isodur_pkg::*;

    // Input register stage
    logic            in_v_reg;
    logic [CH_W-1:0] ch_reg;
    logic            last_reg;

    // Parser state
    phase_t           phase_reg, phase_next;
    logic             time_reg, time_next;
    logic             minus_reg, minus_next;
    logic [NUM_W-1:0] number_reg, number_next;
    logic [NUM_W-1:0] total_reg, total_next;
    logic             failed_reg, failed_next;

    // Result register
    logic             out_v_reg;
    logic [SEC_W-1:0] seconds_reg, seconds_next;

    logic proc;
    logic load_in;
    logic is_digit;
    logic is_ws;
    logic [DIGIT_W-1:0] digit;
    logic [DEC_W-1:0]   dec_sum;
    logic [NUM_W-1:0]   dec_sat;
    logic [MAC_W-1:0]   prod_day, prod_hour, prod_min, prod_sel, mac_sum;
    logic [NUM_W-1:0]   mac_sat;
    logic               unit_ok;

    // Step values after this character, before the end-of-string reset
    phase_t           ph_step;
    logic             time_step, minus_step, failed_step;
    logic [NUM_W-1:0] number_step, total_step;

    // Process the held character unless it is a last one blocked by a full output
    assign proc     = in_v_reg && (!last_reg || !out_v_reg || !out_stall);
    assign load_in  = !in_v_reg || proc;
    assign in_stall = !load_in;

    assign out_valid = out_v_reg;
    assign seconds   = seconds_reg;

    // Character classes
    always_comb
    begin
        is_digit = (ch_reg inside {[CH_ZERO:CH_NINE]});
        is_ws    = (ch_reg == CH_SPACE) || (ch_reg inside {[CH_TAB:CH_CR]});
        digit    = DIGIT_W'(ch_reg - CH_ZERO);
    end

    // Decimal accumulate: number * 10 + digit, saturating at 2^31
    always_comb
    begin
        dec_sum = {1'b0, number_reg, 3'b000} + {3'b000, number_reg, 1'b0}
                + DEC_W'(digit);
        dec_sat = (dec_sum > DEC_W'(SAT_LIMIT)) ? SAT_LIMIT : dec_sum[NUM_W-1:0];
    end

    // Unit multiply-add: total + number * unit, saturating at 2^31
    always_comb
    begin
        prod_day  = MAC_W'(number_reg) * MAC_W'(MULT_DAY);
        prod_hour = MAC_W'(number_reg) * MAC_W'(MULT_HOUR);
        prod_min  = MAC_W'(number_reg) * MAC_W'(MULT_MIN);
        unit_ok   = 1'b1;
        case (ch_reg)
            CH_D:    prod_sel = prod_day;
            CH_H:    prod_sel = prod_hour;
            CH_M:
            begin
                prod_sel = prod_min;
                unit_ok  = time_reg;
            end
            CH_S:    prod_sel = MAC_W'(number_reg);
            default:
            begin
                prod_sel = '0;
                unit_ok  = 1'b0;
            end
        endcase
        mac_sum = MAC_W'(total_reg) + prod_sel;
        mac_sat = (mac_sum > MAC_W'(SAT_LIMIT)) ? SAT_LIMIT : mac_sum[NUM_W-1:0];
    end

    // Next state: advance the parser by one character
    always_comb
    begin
        ph_step     = phase_reg;
        time_step   = time_reg;
        minus_step  = minus_reg;
        number_step = number_reg;
        total_step  = total_reg;
        failed_step = failed_reg;

        if (!failed_reg && phase_reg != PH_ENDED)
        begin
            if (phase_reg == PH_EXPECT_P)
            begin
                if (ch_reg == CH_P)
                    ph_step = PH_TOKEN;
                else
                    failed_step = 1'b1;
            end
            else if (ch_reg == CH_NUL)
            begin
                if (phase_reg == PH_TOKEN)
                    ph_step = PH_ENDED;
                else
                    failed_step = 1'b1;
            end
            else if (is_digit)
            begin
                number_step = dec_sat;
                ph_step     = PH_DIGITS;
            end
            else if (phase_reg == PH_DIGITS)
            begin
                if ((minus_reg && number_reg != '0) || !unit_ok)
                    failed_step = 1'b1;
                else
                begin
                    total_step  = mac_sat;
                    number_step = '0;
                    minus_step  = 1'b0;
                    ph_step     = PH_TOKEN;
                end
            end
            else if (phase_reg == PH_TOKEN && ch_reg == CH_T)
                time_step = 1'b1;
            else if ((phase_reg == PH_TOKEN || phase_reg == PH_SPACE) && is_ws)
                ph_step = PH_SPACE;
            else if ((phase_reg == PH_TOKEN || phase_reg == PH_SPACE)
                     && (ch_reg == CH_PLUS || ch_reg == CH_MINUS))
            begin
                minus_step = (ch_reg == CH_MINUS);
                ph_step    = PH_SIGN;
            end
            else
                failed_step = 1'b1;
        end

        phase_next  = phase_reg;
        time_next   = time_reg;
        minus_next  = minus_reg;
        number_next = number_reg;
        total_next  = total_reg;
        failed_next = failed_reg;
        if (proc)
        begin
            if (last_reg)
            begin
                // End of string: return to the reset state
                phase_next  = PH_EXPECT_P;
                time_next   = 1'b0;
                minus_next  = 1'b0;
                number_next = '0;
                total_next  = '0;
                failed_next = 1'b0;
            end
            else
            begin
                phase_next  = ph_step;
                time_next   = time_step;
                minus_next  = minus_step;
                number_next = number_step;
                total_next  = total_step;
                failed_next = failed_step;
            end
        end
    end

    // Outputs: drop the total to 0 on error, unfinished token or overflow
    always_comb
    begin
        if (!failed_step && (ph_step == PH_TOKEN || ph_step == PH_ENDED)
            && !total_step[NUM_W-1])
            seconds_next = total_step[SEC_W-1:0];
        else
            seconds_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg   <= 1'b0;
            out_v_reg  <= 1'b0;
            phase_reg  <= PH_EXPECT_P;
            time_reg   <= 1'b0;
            minus_reg  <= 1'b0;
            number_reg <= '0;
            total_reg  <= '0;
            failed_reg <= 1'b0;
        end
        else
        begin
            if (load_in)
                in_v_reg <= in_valid;
            if (proc && last_reg)
                out_v_reg <= 1'b1;
            else if (!out_stall)
                out_v_reg <= 1'b0;
            phase_reg  <= phase_next;
            time_reg   <= time_next;
            minus_reg  <= minus_next;
            number_reg <= number_next;
            total_reg  <= total_next;
            failed_reg <= failed_next;
        end
    end

    // Payload registers: hold while stalled
    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            ch_reg   <= ch;
            last_reg <= last;
        end
        if (proc && last_reg)
            seconds_reg <= seconds_next;
    end

endmodule
